[rtl/rpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpq_pkg
// Shared types, action codes and the record ordering key for the record
// max-priority queue.
// ----------------------------------------------------------------------------
package rpq_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_PEEK = 2'd1;
    localparam logic [1:0] ACT_POP  = 2'd2;

    typedef struct packed {
        logic [15:0] score;
        logic [15:0] roll;
        logic [31:0] tag;
    } entry_t;

    // Larger key means higher priority: high score first, then low roll.
    function automatic logic [31:0] prio_key(input entry_t e);
        prio_key = {e.score, ~e.roll};
    endfunction

endpackage
`default_nettype wire

[rtl/record_max_priority_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// record_max_priority_queue_core
// Bounded max-priority queue of records held sorted in a circular buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, roll, score and tag.
//   action 0 pushes a record, 1 peeks, 2 pops; any other code peeks.
//   Every input transaction yields one output transaction (out_valid/
//   out_ready) with the record now on top, or empty_res set and zero fields.
//   A push into a full queue is refused and reports dropped.
// Sequencing:
//   Records sit sorted in a circular buffer; pop only advances the head.
//   Peek, pop and a refused push read the top record, then raise out_valid.
//   A push walks from the tail toward the head, one record per step
//   (memory read, then compare and move), and stops at the first record
//   that does not rank below the new one or at the head; it then writes the
//   new record and reads the top. The single memory read port and the one
//   shared comparator set this step-by-step pace. One transaction is in work
//   at a time; the next can be accepted in the cycle in which out_valid rises.
// Reset: queue empty, output channel idle. Memory contents are not cleared.
// Stall: the result stays in the output register until taken; a new input
//   transaction is accepted meanwhile, and the sequencer waits at its end
//   until the output register is free.
// ----------------------------------------------------------------------------
module record_max_priority_queue_core #(
    parameter int CAPACITY = rpq_pkg::DEF_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] roll,
    input  logic [15:0] score,
    input  logic [31:0] tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        empty_res,
    output logic        dropped,
    output logic [15:0] top_roll,
    output logic [15:0] top_score,
    output logic [31:0] top_tag
);
    import rpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int SW = OW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [OW-1:0] FULL_CNT = OW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_PLACE,
        S_TOP_RD,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [OW-1:0] occ_reg, occ_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [OW-1:0] cnt_reg, cnt_next;
    entry_t        entry_reg, entry_next;
    logic          drop_reg, drop_next;

    logic          out_valid_reg, out_valid_next;
    logic          empty_reg, empty_next;
    logic          dropped_reg, dropped_next;
    entry_t        top_reg, top_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;
    logic          stored_lower;

    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_idx;
    logic [AW-1:0] cur_prev;
    logic [AW-1:0] head_succ;

    rpq_store #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rpq_cmp u_cmp (
        .stored       (mem_rdata),
        .incoming     (entry_reg),
        .stored_lower (stored_lower)
    );

    // Circular index arithmetic
    assign tail_sum  = SW'(head_reg) + SW'(occ_reg);
    assign tail_idx  = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
                                                   : AW'(tail_sum);
    assign cur_prev  = (cur_reg == '0) ? LAST_IDX : cur_reg - 1'b1;
    assign head_succ = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        entry_next     = entry_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        empty_next     = empty_reg;
        dropped_next   = dropped_reg;
        top_next       = top_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = entry_reg;
        mem_re         = 1'b0;
        mem_raddr      = cur_prev;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    entry_next = '{score: score, roll: roll, tag: tag};
                    drop_next  = 1'b0;
                    state_next = S_TOP_RD;
                    case (action)
                        ACT_PUSH:
                        begin
                            if (occ_reg == FULL_CNT)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                cur_next   = tail_idx;
                                cnt_next   = occ_reg;
                                state_next = (occ_reg == '0) ? S_PLACE : S_SCAN_RD;
                            end
                        end
                        ACT_POP:
                        begin
                            if (occ_reg != '0)
                            begin
                                head_next = head_succ;
                                occ_next  = occ_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_TOP_RD;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stored_lower)
                begin
                    // Move the lower-ranked record one slot toward the tail
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    cur_next   = cur_prev;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = (cnt_reg == OW'(1)) ? S_PLACE : S_SCAN_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                occ_next   = occ_reg + 1'b1;
                state_next = S_TOP_RD;
            end
            S_TOP_RD:
            begin
                mem_re     = (occ_reg != '0);
                mem_raddr  = head_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    empty_next     = (occ_reg == '0);
                    dropped_next   = drop_reg;
                    top_next       = (occ_reg == '0) ? '0 : mem_rdata;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            cur_reg       <= '0;
            cnt_reg       <= '0;
            entry_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            empty_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            top_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            cur_reg       <= cur_next;
            cnt_reg       <= cnt_next;
            entry_reg     <= entry_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            empty_reg     <= empty_next;
            dropped_reg   <= dropped_next;
            top_reg       <= top_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign empty_res = empty_reg;
    assign dropped   = dropped_reg;
    assign top_roll  = top_reg.roll;
    assign top_score = top_reg.score;
    assign top_tag   = top_reg.tag;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_CNT)
        else $error("occupancy above capacity");

    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SCAN_CMP || state_reg == S_PLACE))
        else $error("memory write outside insert steps");

    a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PLACE |=> occ_reg == $past(occ_reg) + 1'b1)
        else $error("insert did not grow occupancy");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg) |-> !empty_reg)
        else $error("refused push reported an empty queue");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> (top_reg == '0))
        else $error("empty result carries a record");

endmodule
`default_nettype wire

[rtl/rpq_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpq_cmp
// Shared key comparator: flags a stored record that ranks strictly below the
// record being inserted.
// ----------------------------------------------------------------------------
module rpq_cmp (
    input  rpq_pkg::entry_t stored,
    input  rpq_pkg::entry_t incoming,
    output logic            stored_lower
);
    import rpq_pkg::*;

    // Strict compare keeps equal records in arrival order.
    assign stored_lower = prio_key(stored) < prio_key(incoming);

endmodule
`default_nettype wire

[rtl/rpq_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpq_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpq_store #(
    parameter int CAPACITY = rpq_pkg::DEF_CAPACITY,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  rpq_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output rpq_pkg::entry_t rdata
);
    import rpq_pkg::*;

    entry_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
